FILE: design/trcf_pkg.sv
// Package for the Telnet receive command filter.
// Protocol codes, parse and emitter state types, queue entry types.
// No dependencies.
package trcf_pkg;

  localparam logic [7:0] CODE_IAC    = 8'd255;
  localparam logic [7:0] CODE_DONT   = 8'd254;
  localparam logic [7:0] CODE_DO     = 8'd253;
  localparam logic [7:0] CODE_WONT   = 8'd252;
  localparam logic [7:0] CODE_WILL   = 8'd251;
  localparam logic [7:0] CODE_SB     = 8'd250;
  localparam logic [7:0] CODE_SE     = 8'd240;
  localparam logic [7:0] OPT_BINARY  = 8'd0;
  localparam logic [7:0] OPT_LOGOUT  = 8'd18;

  localparam logic DEST_APP = 1'b0;
  localparam logic DEST_NET = 1'b1;

  typedef enum logic [2:0] {
    PS_NORMAL = 3'd0,
    PS_IAC    = 3'd1,
    PS_DO     = 3'd2,
    PS_DONT   = 3'd3,
    PS_WILL   = 3'd4,
    PS_WONT   = 3'd5,
    PS_SB     = 3'd6
  } parse_state_t;

  typedef enum logic [1:0] {
    BK_HEAD = 2'd0,
    BK_VERB = 2'd1,
    BK_OPT  = 2'd2
  } back_state_t;

  typedef enum logic {
    CMD_DATA  = 1'b0,
    CMD_REPLY = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] value;  // data byte, or option of a reply
    logic [7:0] verb;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_rd_t;

endpackage

FILE: design/trcf_if.sv
// Valid/ready channel interfaces for the Telnet receive command filter.
// Input item carries rx_byte; result item carries out_byte/out_dest/out_last.
// No dependencies.
interface trcf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface trcf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_dest;
  logic       out_last;
  modport source (output valid, output out_byte, output out_dest, output out_last,
                  input ready);
  modport sink (input valid, input out_byte, input out_dest, input out_last,
                output ready);
endinterface

FILE: design/trcf_front.sv
// Front end: accepts received bytes, runs the Telnet parse state machine and
// pushes data or reply commands into the queue. Holds protocol_enable.
// Depends on trcf_pkg, trcf_if.
module trcf_front (
  input  logic                clk,
  input  logic                rst_n,
  trcf_in_if.sink             in_ch,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                q_full,
  output trcf_pkg::q_wr_t     q_wr
);

  trcf_pkg::parse_state_t st_r, st_nxt;
  logic sub_iac_r, sub_iac_nxt;
  logic enable_r;
  logic accept;
  logic [7:0] b;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign b           = in_ch.rx_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= trcf_pkg::PS_NORMAL;
      sub_iac_r <= 1'b0;
      enable_r  <= 1'b1;
    end else begin
      st_r      <= st_nxt;
      sub_iac_r <= sub_iac_nxt;
      if (cfg_we) begin
        enable_r <= cfg_wdata;
      end
    end
  end

  always_comb begin
    st_nxt           = st_r;
    sub_iac_nxt      = sub_iac_r;
    q_wr.push        = 1'b0;
    q_wr.cmd.kind    = trcf_pkg::CMD_DATA;
    q_wr.cmd.value   = b;
    q_wr.cmd.verb    = trcf_pkg::CODE_WONT;
    if (accept) begin
      if (!enable_r) begin
        q_wr.push = 1'b1;
      end else begin
        unique case (st_r)
          trcf_pkg::PS_NORMAL: begin
            if (b == trcf_pkg::CODE_IAC) st_nxt = trcf_pkg::PS_IAC;
            else q_wr.push = 1'b1;
          end
          trcf_pkg::PS_IAC: begin
            case (b)
              trcf_pkg::CODE_IAC: begin
                q_wr.push = 1'b1;
                st_nxt    = trcf_pkg::PS_NORMAL;
              end
              trcf_pkg::CODE_SB:   st_nxt = trcf_pkg::PS_SB;
              trcf_pkg::CODE_DO:   st_nxt = trcf_pkg::PS_DO;
              trcf_pkg::CODE_DONT: st_nxt = trcf_pkg::PS_DONT;
              trcf_pkg::CODE_WILL: st_nxt = trcf_pkg::PS_WILL;
              trcf_pkg::CODE_WONT: st_nxt = trcf_pkg::PS_WONT;
              default:             st_nxt = trcf_pkg::PS_NORMAL;
            endcase
          end
          trcf_pkg::PS_DO: begin
            q_wr.push     = 1'b1;
            q_wr.cmd.kind = trcf_pkg::CMD_REPLY;
            if (b == trcf_pkg::OPT_BINARY || b == trcf_pkg::OPT_LOGOUT) begin
              q_wr.cmd.verb = trcf_pkg::CODE_WILL;
            end
            st_nxt = trcf_pkg::PS_NORMAL;
          end
          trcf_pkg::PS_DONT: begin
            q_wr.push     = 1'b1;
            q_wr.cmd.kind = trcf_pkg::CMD_REPLY;
            st_nxt        = trcf_pkg::PS_NORMAL;
          end
          trcf_pkg::PS_WILL, trcf_pkg::PS_WONT: begin
            st_nxt = trcf_pkg::PS_NORMAL;
          end
          trcf_pkg::PS_SB: begin
            if (!sub_iac_r) begin
              if (b == trcf_pkg::CODE_IAC) sub_iac_nxt = 1'b1;
            end else if (b == trcf_pkg::CODE_IAC) begin
              sub_iac_nxt = 1'b0;
            end else if (b == trcf_pkg::CODE_SE) begin
              sub_iac_nxt = 1'b0;
              st_nxt      = trcf_pkg::PS_NORMAL;
            end
          end
          default: st_nxt = trcf_pkg::PS_NORMAL;
        endcase
      end
    end
  end

endmodule

FILE: design/trcf_queue.sv
// Short command queue between front end and emitter.
// Register-based FIFO of DEPTH entries.
// Depends on trcf_pkg.
module trcf_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  trcf_pkg::q_wr_t  q_wr,
  output logic             q_full,
  output trcf_pkg::q_rd_t  q_rd,
  input  logic             q_pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  trcf_pkg::cmd_t   mem [DEPTH];
  logic [AW-1:0]    wptr_r, rptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign q_full     = (cnt_r == CW'(DEPTH));
  assign q_rd.valid = (cnt_r != '0);
  assign q_rd.cmd   = mem[rptr_r];
  assign do_push    = q_wr.push && !q_full;
  assign do_pop     = q_pop && q_rd.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= q_wr.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (!do_push && do_pop) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

FILE: design/trcf_back.sv
// Emitter: pops commands and drives the registered result channel, one beat
// for a data byte, three beats (IAC, verb, option) for a reply.
// Depends on trcf_pkg, trcf_if.
module trcf_back (
  input  logic             clk,
  input  logic             rst_n,
  input  trcf_pkg::q_rd_t  q_rd,
  output logic             q_pop,
  trcf_out_if.source       out_ch
);

  trcf_pkg::back_state_t st_r, st_nxt;
  trcf_pkg::cmd_t        cur_r, cur_nxt;
  logic                  valid_r, valid_nxt;
  logic [7:0]            byte_r, byte_nxt;
  logic                  dest_r, dest_nxt;
  logic                  last_r, last_nxt;
  logic                  out_free;

  assign out_ch.valid    = valid_r;
  assign out_ch.out_byte = byte_r;
  assign out_ch.out_dest = dest_r;
  assign out_ch.out_last = last_r;
  assign out_free        = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= trcf_pkg::BK_HEAD;
      valid_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    byte_r <= byte_nxt;
    dest_r <= dest_nxt;
    last_r <= last_nxt;
  end

  always_comb begin
    st_nxt    = st_r;
    cur_nxt   = cur_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    dest_nxt  = dest_r;
    last_nxt  = last_r;
    q_pop     = 1'b0;
    if (out_free) begin
      valid_nxt = 1'b0;
      unique case (st_r)
        trcf_pkg::BK_HEAD: begin
          if (q_rd.valid) begin
            q_pop     = 1'b1;
            cur_nxt   = q_rd.cmd;
            valid_nxt = 1'b1;
            if (q_rd.cmd.kind == trcf_pkg::CMD_DATA) begin
              byte_nxt = q_rd.cmd.value;
              dest_nxt = trcf_pkg::DEST_APP;
              last_nxt = 1'b1;
            end else begin
              byte_nxt = trcf_pkg::CODE_IAC;
              dest_nxt = trcf_pkg::DEST_NET;
              last_nxt = 1'b0;
              st_nxt   = trcf_pkg::BK_VERB;
            end
          end
        end
        trcf_pkg::BK_VERB: begin
          valid_nxt = 1'b1;
          byte_nxt  = cur_r.verb;
          dest_nxt  = trcf_pkg::DEST_NET;
          last_nxt  = 1'b0;
          st_nxt    = trcf_pkg::BK_OPT;
        end
        trcf_pkg::BK_OPT: begin
          valid_nxt = 1'b1;
          byte_nxt  = cur_r.value;
          dest_nxt  = trcf_pkg::DEST_NET;
          last_nxt  = 1'b1;
          st_nxt    = trcf_pkg::BK_HEAD;
        end
        default: st_nxt = trcf_pkg::BK_HEAD;
      endcase
    end
  end

endmodule

FILE: design/telnet_receive_command_filter_top.sv
// Top level of the Telnet receive command filter: front end, queue, emitter.
// Depends on trcf_pkg, trcf_if, trcf_front, trcf_queue, trcf_back.
//
//   channel  dir  handshake         payload
//   in_ch    in   valid/ready       rx_byte[7:0]
//   out_ch   out  valid/ready       out_byte[7:0], out_dest, out_last
//   cfg      in   cfg_we (no wait)  cfg_wdata = protocol_enable
//
// One received byte accepted per cycle while the queue has room.
// A data item passes through the queue and the result register; a reply
// leaves as three beats from the emitter's single result register.
// Synchronous active-low reset: normal parse state, enable set, queue empty.
// in_ch.ready drops only when the QUEUE_DEPTH-entry command queue is full.
module telnet_receive_command_filter_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  trcf_in_if.sink      in_ch,
  trcf_out_if.source   out_ch,
  input  logic         cfg_we,
  input  logic         cfg_wdata
);

  trcf_pkg::q_wr_t q_wr;
  trcf_pkg::q_rd_t q_rd;
  logic            q_full;
  logic            q_pop;

  trcf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_wr      (q_wr)
  );

  trcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  trcf_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rd   (q_rd),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

FILE: design/trcf_checker.sv
// Port-level checks for the Telnet receive command filter, bound to the top.
// Depends on telnet_receive_command_filter_top, trcf_pkg.
module trcf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_dest,
  input logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_dest)
      && $stable(out_last))
    else $error("result item changed while stalled");

  a_data_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dest == trcf_pkg::DEST_APP |-> out_last)
    else $error("data item not marked last");

  a_reply_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dest == trcf_pkg::DEST_NET && !out_last |->
      out_byte == trcf_pkg::CODE_IAC || out_byte == trcf_pkg::CODE_WILL
      || out_byte == trcf_pkg::CODE_WONT)
    else $error("bad reply header byte");

  a_reply_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_dest == trcf_pkg::DEST_NET && !out_last |=>
      out_valid && out_dest == trcf_pkg::DEST_NET)
    else $error("reply broken off");

endmodule

bind telnet_receive_command_filter_top trcf_checker u_trcf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_dest  (out_ch.out_dest),
  .out_last  (out_ch.out_last)
);
